// ----- rtl/vsm_pkg.sv -----
// ----------------------------------------------------------------------------
// vsm_pkg - shared types and constants for the vector softmax core
// Sizes of the element buffers, arithmetic widths and the sequencer states.
// ----------------------------------------------------------------------------
package vsm_pkg;

    // buffer depth and derived widths
    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W        = 16 + CNT_W;

    // data widths
    localparam int X_W    = 16;
    localparam int E_W    = 16;
    localparam int DVD_W  = 33;
    localparam int DVS_W  = 32;

    // exponential series
    localparam int TAYLOR_TERMS = 13;
    localparam int SQUARINGS    = 4;
    localparam int K_W          = 4;
    localparam int SQ_W         = 2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD,
        S_T,
        S_MUL,
        S_DIVS,
        S_DIVW,
        S_SQ,
        S_SQR,
        S_WR,
        S_PRD,
        S_PDS,
        S_PDW,
        S_OUT
    } t_state;

endpackage

// ----- rtl/vector_softmax_core.sv -----
// ----------------------------------------------------------------------------
// vector_softmax_core - max-subtracted softmax over a loaded vector
// Loads Q8.8 elements, then emits Q0.16 probabilities in load order.
// ----------------------------------------------------------------------------
// Elements load at one word per cycle into a 64-entry buffer while the running
// maximum is tracked; words beyond the depth are dropped and flag overflow. The
// word marked last starts the computation and the block is not ready again until
// the final probability has been taken. Each exp(x - max) runs 13 Taylor terms,
// each a multiply plus a divide by the term index on the shared divider (33
// iterations), then four squarings on the shared multiplier; a difference out of
// range skips the series and gives zero. Each probability then takes one
// division on the shared divider and waits for the output handshake.
module vector_softmax_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_x_value,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_prob,
    output logic        o_last_out,
    output logic        o_overflow
);

    localparam int CW  = vsm_pkg::CNT_W;
    localparam int IW  = vsm_pkg::IDX_W;
    localparam int SW  = vsm_pkg::SUM_W;

    vsm_pkg::t_state r_state, n_state;

    logic [CW-1:0]                r_cnt, n_cnt;
    logic [CW-1:0]                r_idx, n_idx;
    logic signed [vsm_pkg::X_W-1:0] r_max, n_max;
    logic [SW-1:0]                r_sum, n_sum;
    logic                         r_drop, n_drop;
    logic [vsm_pkg::K_W-1:0]      r_k, n_k;
    logic [vsm_pkg::SQ_W-1:0]     r_sq, n_sq;
    logic                         r_ovalid, n_ovalid;

    logic [30:0]                  r_z, n_z;
    logic [31:0]                  r_term, n_term;
    logic [32:0]                  r_pos, n_pos;
    logic [32:0]                  r_neg, n_neg;
    logic [31:0]                  r_r, n_r;
    logic [63:0]                  r_prod, n_prod;
    logic [15:0]                  r_e, n_e;
    logic [15:0]                  r_prob, n_prob;
    logic                         r_last, n_last;

    // memory and divider hookups
    logic                         w_vwe, w_ewe;
    logic [IW-1:0]                w_vwaddr, w_raddr;
    logic [15:0]                  w_vrdata, w_erdata;
    logic                         w_dstart, w_ddone;
    logic [vsm_pkg::DVD_W-1:0]    w_ddvd, w_dquot;
    logic [vsm_pkg::DVS_W-1:0]    w_ddvs;
    logic [31:0]                  w_ma, w_mb;
    logic signed [16:0]           w_diff;
    logic [31:0]                  w_sqr;
    logic [32:0]                  w_rnd;
    logic [15:0]                  w_eq;
    logic                         w_acc;

    vsm_ram #(.P_WIDTH(16), .P_DEPTH(vsm_pkg::MAX_ELEMENTS)) u_vbuf (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (w_vwaddr),
        .i_wdata (i_x_value),
        .i_raddr (w_raddr),
        .o_rdata (w_vrdata)
    );

    vsm_ram #(.P_WIDTH(16), .P_DEPTH(vsm_pkg::MAX_ELEMENTS)) u_ebuf (
        .i_clk   (i_clk),
        .i_we    (w_ewe),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (r_e),
        .i_raddr (w_raddr),
        .o_rdata (w_erdata)
    );

    vsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_ddvd),
        .i_divisor  (w_ddvs),
        .o_done     (w_ddone),
        .o_quot     (w_dquot)
    );

    assign w_acc    = i_valid && o_ready;
    assign o_ready  = (r_state == vsm_pkg::S_LOAD);
    assign w_vwe    = w_acc && (r_cnt < CW'(vsm_pkg::MAX_ELEMENTS));
    assign w_vwaddr = r_cnt[IW-1:0];
    assign w_raddr  = r_idx[IW-1:0];
    assign w_ewe    = (r_state == vsm_pkg::S_WR);
    assign w_dstart = (r_state == vsm_pkg::S_DIVS) || (r_state == vsm_pkg::S_PDS);

    // divider operands: series term over k, or scaled exp over sum
    always_comb begin
        if (r_state == vsm_pkg::S_PDS) begin
            w_ddvd = {1'b0, w_erdata, 16'd0} + vsm_pkg::DVD_W'(r_sum >> 1);
            w_ddvs = vsm_pkg::DVS_W'(r_sum);
        end else begin
            w_ddvd = r_prod[63:31];
            w_ddvs = vsm_pkg::DVS_W'(r_k);
        end
    end

    // shared multiplier operands
    assign w_ma   = (r_state == vsm_pkg::S_SQ) ? r_r : r_term;
    assign w_mb   = (r_state == vsm_pkg::S_SQ) ? r_r : {1'b0, r_z};
    assign w_diff = {r_max[15], r_max} - {w_vrdata[15], w_vrdata};

    // rounded square in Q1.31, then rounded and saturated to Q0.16
    assign w_sqr  = 32'((r_prod + (64'd1 << 30)) >> 31);
    assign w_rnd  = {1'b0, w_sqr} + 33'd16384;
    assign w_eq   = (w_rnd[32:31] != 2'd0) ? 16'hFFFF : w_rnd[30:15];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vsm_pkg::S_LOAD;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_max    <= 16'sh8000;
            r_sum    <= '0;
            r_drop   <= 1'b0;
            r_k      <= '0;
            r_sq     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_max    <= n_max;
            r_sum    <= n_sum;
            r_drop   <= n_drop;
            r_k      <= n_k;
            r_sq     <= n_sq;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_z    <= n_z;
        r_term <= n_term;
        r_pos  <= n_pos;
        r_neg  <= n_neg;
        r_r    <= n_r;
        r_prod <= n_prod;
        r_e    <= n_e;
        r_prob <= n_prob;
        r_last <= n_last;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_max    = r_max;
        n_sum    = r_sum;
        n_drop   = r_drop;
        n_k      = r_k;
        n_sq     = r_sq;
        n_ovalid = r_ovalid;
        n_z      = r_z;
        n_term   = r_term;
        n_pos    = r_pos;
        n_neg    = r_neg;
        n_r      = r_r;
        n_prod   = r_prod;
        n_e      = r_e;
        n_prob   = r_prob;
        n_last   = r_last;
        case (r_state)
            vsm_pkg::S_LOAD: begin
                if (w_acc) begin
                    if (r_cnt < CW'(vsm_pkg::MAX_ELEMENTS)) begin
                        n_cnt = r_cnt + CW'(1);
                        if ($signed(i_x_value) > r_max) begin
                            n_max = $signed(i_x_value);
                        end
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_is_last) begin
                        n_idx   = '0;
                        n_sum   = '0;
                        n_state = vsm_pkg::S_RD;
                    end
                end
            end
            vsm_pkg::S_RD: begin
                n_state = vsm_pkg::S_T;
            end
            vsm_pkg::S_T: begin
                // out of range difference gives zero
                if (w_diff[16:12] != 5'd0) begin
                    n_e     = '0;
                    n_state = vsm_pkg::S_WR;
                end else begin
                    n_z     = {w_diff[11:0], 19'd0};
                    n_term  = 32'h8000_0000;
                    n_pos   = 33'h0_8000_0000;
                    n_neg   = '0;
                    n_k     = vsm_pkg::K_W'(1);
                    n_state = vsm_pkg::S_MUL;
                end
            end
            vsm_pkg::S_MUL: begin
                n_prod  = w_ma * w_mb;
                n_state = vsm_pkg::S_DIVS;
            end
            vsm_pkg::S_DIVS: begin
                n_state = vsm_pkg::S_DIVW;
            end
            vsm_pkg::S_DIVW: begin
                if (w_ddone) begin
                    n_term = w_dquot[31:0];
                    if (r_k[0]) begin
                        n_neg = r_neg + {1'b0, w_dquot[31:0]};
                    end else begin
                        n_pos = r_pos + {1'b0, w_dquot[31:0]};
                    end
                    if (r_k == vsm_pkg::K_W'(vsm_pkg::TAYLOR_TERMS)) begin
                        n_sq    = '0;
                        n_state = vsm_pkg::S_SQ;
                    end else begin
                        n_k     = r_k + vsm_pkg::K_W'(1);
                        n_state = vsm_pkg::S_MUL;
                    end
                end
            end
            vsm_pkg::S_SQ: begin
                // first pass: series result still in pos/neg
                if (r_sq == '0 && r_k != '0) begin
                    n_r = 32'(r_pos - r_neg);
                    n_k = '0;
                end else begin
                    n_prod  = w_ma * w_mb;
                    n_state = vsm_pkg::S_SQR;
                end
            end
            vsm_pkg::S_SQR: begin
                n_r = w_sqr;
                if (r_sq == vsm_pkg::SQ_W'(vsm_pkg::SQUARINGS - 1)) begin
                    // last squaring: round to Q0.16 for the write
                    n_e     = w_eq;
                    n_state = vsm_pkg::S_WR;
                end else begin
                    n_sq    = r_sq + vsm_pkg::SQ_W'(1);
                    n_state = vsm_pkg::S_SQ;
                end
            end
            vsm_pkg::S_WR: begin
                // exp word goes to the buffer and into the sum
                n_sum = r_sum + SW'(r_e);
                n_idx = r_idx + CW'(1);
                n_k   = '0;
                if (r_idx + CW'(1) == r_cnt) begin
                    n_idx   = '0;
                    n_state = vsm_pkg::S_PRD;
                end else begin
                    n_state = vsm_pkg::S_RD;
                end
            end
            vsm_pkg::S_PRD: begin
                n_state = vsm_pkg::S_PDS;
            end
            vsm_pkg::S_PDS: begin
                n_state = vsm_pkg::S_PDW;
            end
            vsm_pkg::S_PDW: begin
                if (w_ddone) begin
                    if (w_dquot[32:16] != 17'd0) begin
                        n_prob = 16'hFFFF;
                    end else begin
                        n_prob = w_dquot[15:0];
                    end
                    n_last   = (r_idx + CW'(1) == r_cnt);
                    n_ovalid = 1'b1;
                    n_state  = vsm_pkg::S_OUT;
                end
            end
            vsm_pkg::S_OUT: begin
                if (i_ready) begin
                    n_ovalid = 1'b0;
                    if (r_idx + CW'(1) == r_cnt) begin
                        n_idx   = '0;
                        n_cnt   = '0;
                        n_max   = 16'sh8000;
                        n_sum   = '0;
                        n_drop  = 1'b0;
                        n_state = vsm_pkg::S_LOAD;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = vsm_pkg::S_PRD;
                    end
                end
            end
            default: begin
                n_state = vsm_pkg::S_LOAD;
            end
        endcase
    end

    assign o_valid    = r_ovalid;
    assign o_prob     = r_prob;
    assign o_last_out = r_last;
    assign o_overflow = r_drop;

endmodule

// ----- rtl/vsm_ram.sv -----
// ----------------------------------------------------------------------------
// vsm_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module vsm_ram #(
    parameter int P_WIDTH = 16,
    parameter int P_DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]                     i_wdata,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]                     o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/vsm_div.sv -----
// ----------------------------------------------------------------------------
// vsm_div - iterative restoring divider
// One quotient bit per cycle; done pulses for one cycle with the quotient held.
// ----------------------------------------------------------------------------
module vsm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vsm_pkg::DVD_W-1:0]  i_dividend,
    input  logic [vsm_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [vsm_pkg::DVD_W-1:0]  o_quot
);

    localparam int CW = $clog2(vsm_pkg::DVD_W + 1);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [vsm_pkg::DVD_W-1:0] r_dvd, n_dvd;
    logic [vsm_pkg::DVS_W-1:0] r_dvs, n_dvs;
    logic [vsm_pkg::DVS_W-1:0] r_rem, n_rem;
    logic [vsm_pkg::DVS_W:0]   w_sh;
    logic [vsm_pkg::DVS_W:0]   w_diff;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    // shift in next dividend bit, trial subtract
    assign w_sh   = {r_rem, r_dvd[vsm_pkg::DVD_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(vsm_pkg::DVD_W);
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (!w_diff[vsm_pkg::DVS_W]) begin
                n_rem = w_diff[vsm_pkg::DVS_W-1:0];
                n_dvd = {r_dvd[vsm_pkg::DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_sh[vsm_pkg::DVS_W-1:0];
                n_dvd = {r_dvd[vsm_pkg::DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

// ----- tb/vsm_checker.sv -----
// ----------------------------------------------------------------------------
// vsm_checker - scoreboard for the vector softmax core
// Watches both channels, predicts the probabilities of each vector and
// compares every output word with the oldest predicted word.
// ----------------------------------------------------------------------------
module vsm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [15:0] i_x_value,
    input  logic        i_is_last,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [15:0] i_prob,
    input  logic        i_last_out,
    input  logic        i_overflow,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] prob;
        logic        last_out;
        logic        overflow;
    } t_prob_word;

    // shadow of the vector state
    logic signed [15:0] vec_elems [vsm_pkg::MAX_ELEMENTS];
    logic signed [15:0] vec_max;
    int                 vec_count;
    logic               vec_dropped;
    t_prob_word         prob_queue [$];

    assign o_pending = prob_queue.size();

    // exp(-t/256) in Q0.16: Taylor series then four squarings
    function automatic logic [15:0] exp_neg(input logic [31:0] t);
        logic [63:0] z, term, pos, neg, r;
        if (t >= 32'd4096) return 16'd0;
        z = 64'(t) << 19;
        term = 64'd1 << 31;
        pos = term;
        neg = 0;
        for (int k = 1; k <= vsm_pkg::TAYLOR_TERMS; k++) begin
            term = ((term * z) >> 31) / k;
            if (k % 2) neg += term;
            else pos += term;
        end
        r = pos - neg;
        for (int k = 0; k < vsm_pkg::SQUARINGS; k++)
            r = (r * r + (64'd1 << 30)) >> 31;
        r = (r + 64'd16384) >> 15;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    // predict the burst of probabilities for the loaded vector
    task automatic predict_vector();
        logic [15:0] ex [vsm_pkg::MAX_ELEMENTS];
        logic [63:0] sum, p;
        t_prob_word  w;
        sum = 0;
        for (int i = 0; i < vec_count; i++) begin
            ex[i] = exp_neg(32'(int'(vec_max) - int'(vec_elems[i])));
            sum += ex[i];
        end
        for (int i = 0; i < vec_count; i++) begin
            p = ((64'(ex[i]) << 16) + (sum >> 1)) / sum;
            w.prob = (p > 64'd65535) ? 16'hFFFF : p[15:0];
            w.last_out = (i + 1 == vec_count);
            w.overflow = vec_dropped;
            prob_queue = {prob_queue, w};
        end
        vec_max = -16'sd32768;
        vec_count = 0;
        vec_dropped = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_prob_word w;
        if (!i_rst_n) begin
            vec_max = -16'sd32768;
            vec_count = 0;
            vec_dropped = 1'b0;
            o_errors <= 0;
        end else begin
            // output side first: burst cannot overlap the load of its own vector
            if (i_out_valid && i_ready) begin
                if (prob_queue.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected word prob=%h last=%b ovf=%b",
                                 i_prob, i_last_out, i_overflow);
                    o_errors <= o_errors + 1;
                end else begin
                    w = prob_queue.pop_front();
                    if (w.prob !== i_prob || w.last_out !== i_last_out ||
                        w.overflow !== i_overflow) begin
                        if (o_errors < 10)
                            $display("mismatch exp prob=%h last=%b ovf=%b got %h %b %b",
                                     w.prob, w.last_out, w.overflow,
                                     i_prob, i_last_out, i_overflow);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                if (vec_count < vsm_pkg::MAX_ELEMENTS) begin
                    vec_elems[vec_count] = i_x_value;
                    if ($signed(i_x_value) > vec_max) vec_max = i_x_value;
                    vec_count = vec_count + 1;
                end else begin
                    vec_dropped = 1'b1;
                end
                if (i_is_last) predict_vector();
            end
        end
    end
endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for the vector softmax core
// Drives directed and random vectors with bursty input and a stalling output;
// the checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_x_value = '0;
    logic        i_is_last = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_last_out, o_overflow;
    logic [15:0] o_prob;
    int          err_count, pending;
    int          idle_cycles = 0;
    bit          long_stall = 1'b0;
    bit          timed_out = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    vector_softmax_core DUT (.*);

    vsm_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_x_value(i_x_value), .i_is_last(i_is_last), .i_out_valid(o_valid),
        .i_ready(i_ready), .i_prob(o_prob), .i_last_out(o_last_out),
        .i_overflow(o_overflow), .o_errors(err_count), .o_pending(pending)
    );

    // receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || long_stall) i_ready <= 1'b0;
        else case ($urandom_range(3))
            0: i_ready <= 1'b0;
            1: i_ready <= ($urandom_range(7) == 0);
            default: i_ready <= 1'b1;
        endcase
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || long_stall) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL vector_softmax_core");
            $finish;
        end
    end

    // offer one word and wait for acceptance
    task automatic send_word(input logic [15:0] x, input logic last);
        i_valid <= 1'b1;
        i_x_value <= x;
        i_is_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_vector(input int len, input int mode);
        logic [15:0] x, base;
        base = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: x = 16'($urandom);
                1: x = 16'(base + $urandom_range(1200) - 600);
                default: x = 16'(base + $urandom_range(5000) - 2500);
            endcase
            send_word(x, i == len - 1);
            // random gaps between bursts
            if ($urandom_range(3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(6)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        int len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: single element, extremes, ties, far out-of-range spread
        send_word(16'h8000, 1'b1);
        send_word(16'h7FFF, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b1);
        send_word(16'h0100, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hF100, 1'b0);
        send_word(16'h1000, 1'b0);
        send_word(16'h0FFF, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b1);
        i_valid <= 1'b0;
        // full buffer plus dropped words, last one dropped too
        for (int i = 0; i < vsm_pkg::MAX_ELEMENTS + 3; i++)
            send_word(16'(16'h0100 + i * 7), i == vsm_pkg::MAX_ELEMENTS + 2);
        i_valid <= 1'b0;
        // sender pause until drained
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // long receiver hold-off while the sender keeps offering
        long_stall <= 1'b1;
        fork
            begin
                send_vector(5, 1);
                send_vector(3, 1);
            end
            begin
                repeat (4000) @(posedge i_clk);
                long_stall <= 1'b0;
            end
        join
        // random vectors, mostly short
        for (int n = 0; n < 330; n += len) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 6);
            send_vector(len, $urandom_range(2));
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_count == 0 && pending == 0) $display("PASS vector_softmax_core");
        else $display("FAIL vector_softmax_core");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/vsm_pkg.sv
rtl/vsm_ram.sv
rtl/vsm_div.sv
rtl/vector_softmax_core.sv
tb/vsm_checker.sv
tb/tb.sv
